/* hdl/guest_interrupt_injection_queue_macros.svh */
// Assertion macros shared by the queue RTL.
`ifndef GUEST_INTERRUPT_INJECTION_QUEUE_MACROS_SVH
`define GUEST_INTERRUPT_INJECTION_QUEUE_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define GII_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition implies another in the following cycle.
`define GII_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/gii_pkg.sv */
package gii_pkg;

   // Default queue depth.
   localparam int unsigned QUEUE_DEPTH_DEF = 32;

   // Event kinds carried in the mode field.
   localparam logic MODE_EXT_IRQ = 1'b0;
   localparam logic MODE_WINDOW  = 1'b1;

   // Guest activity states that leave the interrupt window open.
   localparam logic [1:0] ACT_ACTIVE = 2'd0;
   localparam logic [1:0] ACT_HALT   = 2'd1;

   // Injection word fields.
   localparam logic [2:0] INFO_TYPE_EXT = 3'd0;
   localparam logic       INFO_VALID    = 1'b1;

   typedef struct packed {
      logic       mode;
      logic [7:0] vector;
      logic       guest_if;
      logic [1:0] activity_state;
      logic       sti_blocking;
      logic       movss_blocking;
   } req_type;

   typedef struct packed {
      logic        inject;
      logic [31:0] injection_info;
      logic        host_eoi;
      logic        window_exiting;
      logic        overflow;
      logic        empty_error;
      logic [5:0]  pending;
   } rsp_type;

   // Pack a vector into an external-interrupt injection word.
   function automatic logic [31:0] make_word(logic [7:0] vec);
      return {INFO_VALID, 20'd0, INFO_TYPE_EXT, vec};
   endfunction

endpackage

/* hdl/gii_ram.sv */
module gii_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, read one entry (old data on a clash).
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/guest_interrupt_injection_queue.sv */
// Channel | Direction | Handshake             | Word
// req     | in        | req_valid / req_ready | gii_pkg::req_type (event and guest state)
// rsp     | out       | rsp_valid / rsp_ready | gii_pkg::rsp_type (injection and status)
//
// One word is accepted per cycle unless the response stalls; each gives exactly
// one response, through an input register and a result register.
// The queue head is prefetched from the vector RAM, so a pop does not wait for a RAM read.
// Reset empties the queue at once; the RAM contents are never cleared.
// A stalled response holds the input register, which then holds req_ready low.
module guest_interrupt_injection_queue #(
   parameter int unsigned QUEUE_DEPTH = gii_pkg::QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  gii_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output gii_pkg::rsp_type rsp_data
);

   import gii_pkg::*;

   localparam int unsigned AW = $clog2(QUEUE_DEPTH);
   localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned SW = AW + 1;
   localparam int unsigned PW = (CW > 6) ? CW : 6;

   logic            s1_valid_ff;
   req_type         s1_data_ff;
   logic            rsp_valid_ff;
   rsp_type         rsp_data_ff;
   rsp_type         rsp_data_in;

   logic [AW-1:0]   head_ff, head_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            armed_ff, armed_in;
   logic            byp_ff, byp_in;
   logic [7:0]      byp_data_ff;

   logic            s1_adv;
   logic            is_ext;
   logic            win_open;
   logic            full;
   logic            has_entry;
   logic            push;
   logic            pop;
   logic [SW-1:0]   tail_sum;
   logic [SW-1:0]   tail_wrap;
   logic [AW-1:0]   tail_idx;
   logic [7:0]      ram_rd_data;
   logic [7:0]      head_vec;
   logic [7:0]      out_vec;
   logic            out_inject;
   logic [PW-1:0]   count_ext;

   // Advance the input word when the result register is free or being taken.
   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Decode the event and the guest window.
   assign is_ext    = (s1_data_ff.mode == MODE_EXT_IRQ);
   assign win_open  = s1_data_ff.guest_if
                      && (s1_data_ff.activity_state == ACT_ACTIVE
                          || s1_data_ff.activity_state == ACT_HALT)
                      && !s1_data_ff.sti_blocking && !s1_data_ff.movss_blocking;
   assign full      = (count_ff == CW'(QUEUE_DEPTH));
   assign has_entry = (count_ff != '0);
   assign push      = s1_adv && is_ext && !win_open && !full;
   assign pop       = s1_adv && !is_ext && has_entry;

   // Tail slot, wrapped once round the ring.
   assign tail_sum  = SW'(head_ff) + SW'(count_ff);
   assign tail_wrap = (tail_sum >= SW'(QUEUE_DEPTH)) ? tail_sum - SW'(QUEUE_DEPTH) : tail_sum;
   assign tail_idx  = tail_wrap[AW-1:0];

   // Next queue state.
   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      armed_in = armed_ff;
      if (pop) begin
         head_in  = (head_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + AW'(1);
         count_in = count_ff - CW'(1);
      end else if (push) begin
         count_in = count_ff + CW'(1);
      end
      if (s1_adv) begin
         if (!is_ext) begin
            armed_in = (count_in != '0);
         end else if (!win_open) begin
            armed_in = 1'b1;
         end
      end
   end

   // Prefetch the next head; bypass a write landing on it this cycle.
   assign byp_in   = push && (tail_idx == head_in);
   assign head_vec = byp_ff ? byp_data_ff : ram_rd_data;

   gii_ram #(
      .WIDTH (8),
      .DEPTH (QUEUE_DEPTH)
   ) u_vec_ram (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (tail_idx),
      .wr_data (s1_data_ff.vector),
      .rd_addr (head_in),
      .rd_data (ram_rd_data)
   );

   // Build the response word.
   assign out_inject = is_ext ? win_open : has_entry;
   assign out_vec    = is_ext ? s1_data_ff.vector : head_vec;
   assign count_ext  = PW'(count_in);

   always_comb begin
      rsp_data_in.inject         = out_inject;
      rsp_data_in.injection_info = out_inject ? make_word(out_vec) : 32'd0;
      rsp_data_in.host_eoi       = is_ext;
      rsp_data_in.window_exiting = armed_in;
      rsp_data_in.overflow       = is_ext && !win_open && full;
      rsp_data_in.empty_error    = !is_ext && !has_entry;
      rsp_data_in.pending        = count_ext[5:0];
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         head_ff      <= '0;
         count_ff     <= '0;
         armed_ff     <= 1'b0;
         byp_ff       <= 1'b0;
      end else begin
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (s1_adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         head_ff  <= head_in;
         count_ff <= count_in;
         armed_ff <= armed_in;
         byp_ff   <= byp_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_data_ff <= req_data;
      end
      if (s1_adv) begin
         rsp_data_ff <= rsp_data_in;
      end
      byp_data_ff <= s1_data_ff.vector;
   end

`include "guest_interrupt_injection_queue_macros.svh"

   `GII_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(QUEUE_DEPTH), "queue count beyond depth")
   `GII_ASSERT_SAME(a_armed_tracks_count, clock, reset, 1'b1, armed_ff == (count_ff != '0), "window arming out of step with queue")
   `GII_ASSERT_SAME(a_overflow_shape, clock, reset, rsp_valid_ff && rsp_data_ff.overflow, rsp_data_ff.host_eoi && rsp_data_ff.window_exiting && !rsp_data_ff.inject, "bad overflow response")
   `GII_ASSERT_SAME(a_info_valid, clock, reset, rsp_valid_ff, rsp_data_ff.inject == rsp_data_ff.injection_info[31], "injection word valid bit mismatch")
   `GII_ASSERT_NEXT(a_push_counts, clock, reset, push, count_ff == $past(count_ff) + CW'(1), "push did not raise the count")

endmodule

/* tb/sv/tb.sv */
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import gii_pkg::*;

   localparam int unsigned SLOTS      = QUEUE_DEPTH_DEF;
   localparam int unsigned SLOT_AW    = $clog2(SLOTS);
   localparam int unsigned EVENTS     = 2000;
   localparam int unsigned STALL_MAX  = 2000;
   localparam int unsigned DRAIN_WAIT = 4;

   // Activity states that keep the window shut
   localparam logic [1:0] ACT_SHUTDOWN = 2'd2;
   localparam logic [1:0] ACT_SIPI     = 2'd3;

   // Kinds of generated event
   localparam int EV_SHUT_IRQ = 0;
   localparam int EV_OPEN_IRQ = 1;
   localparam int EV_WINDOW   = 2;
   localparam int EV_ANY      = 3;

   // Tracks the guest queue and holds the responses still owed by the block
   class injection_scoreboard;
      logic [7:0]  slots [SLOTS];
      int unsigned head;
      int unsigned fill;
      logic        armed;
      rsp_type     owed [$];
      int unsigned faults;

      function new();
         head   = 0;
         fill   = 0;
         armed  = 1'b0;
         faults = 0;
      endfunction

      function int unsigned awaited();
         return owed.size();
      endfunction

      // Work out the response to an accepted event and advance the queue
      function void note_event(req_type w);
         rsp_type r;
         logic    open_now;
         r = '0;
         open_now = w.guest_if && !w.sti_blocking && !w.movss_blocking &&
                    (w.activity_state == ACT_ACTIVE || w.activity_state == ACT_HALT);
         if (w.mode == MODE_EXT_IRQ) begin
            r.host_eoi = 1'b1;
            if (open_now) begin
               r.inject                 = 1'b1;
               r.injection_info[31]     = INFO_VALID;
               r.injection_info[10:8]   = INFO_TYPE_EXT;
               r.injection_info[7:0]    = w.vector;
            end else begin
               armed = 1'b1;
               if (fill < SLOTS) begin
                  slots[SLOT_AW'((head + fill) % SLOTS)] = w.vector;
                  fill++;
               end else begin
                  r.overflow = 1'b1;
               end
            end
         end else begin
            if (fill == 0) begin
               r.empty_error = 1'b1;
            end else begin
               r.inject               = 1'b1;
               r.injection_info[31]   = INFO_VALID;
               r.injection_info[10:8] = INFO_TYPE_EXT;
               r.injection_info[7:0]  = slots[SLOT_AW'(head)];
               head = (head + 1) % SLOTS;
               fill--;
            end
            armed = (fill != 0);
         end
         r.window_exiting = armed;
         r.pending        = fill[5:0];
         owed = {owed, r};
      endfunction

      function void compare_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
         if (exp_v !== got_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, got_v);
            faults++;
         end
      endfunction

      // Match a response word against the oldest one owed
      function void check_response(rsp_type got);
         rsp_type exp_w;
         if (owed.size() == 0) begin
            $error("response word with nothing owed: %0h", got);
            faults++;
            return;
         end
         exp_w = owed[0];
         owed.delete(0);
         compare_field("inject", exp_w.inject, got.inject);
         compare_field("injection_info", exp_w.injection_info, got.injection_info);
         compare_field("host_eoi", exp_w.host_eoi, got.host_eoi);
         compare_field("window_exiting", exp_w.window_exiting, got.window_exiting);
         compare_field("overflow", exp_w.overflow, got.overflow);
         compare_field("empty_error", exp_w.empty_error, got.empty_error);
         compare_field("pending", exp_w.pending, got.pending);
      endfunction
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Set while neither side idles
   bit          steady_run = 1'b0;
   int unsigned quiet_cycles = 0;

   injection_scoreboard sb = new();

   guest_interrupt_injection_queue #(
      .QUEUE_DEPTH(SLOTS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Stall the response side now and then
   always @(posedge clock) begin
      rsp_ready <= steady_run || ($urandom_range(0, 99) >= 11);
   end

   // Watch both channels: check responses first, then note new events
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            sb.check_response(rsp_data);
         end
         if (req_valid && req_ready) begin
            sb.note_event(req_data);
         end
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
   end

   // End the run if nothing moves for too long
   initial begin
      while (quiet_cycles < STALL_MAX) begin
         @(posedge clock);
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic req_type event_word(logic mode, logic [7:0] vec, logic gif,
                                          logic [1:0] act, logic sti, logic mss);
      req_type w;
      w.mode           = mode;
      w.vector         = vec;
      w.guest_if       = gif;
      w.activity_state = act;
      w.sti_blocking   = sti;
      w.movss_blocking = mss;
      return w;
   endfunction

   // Build a random event of the given kind
   function automatic req_type random_event(int kind);
      req_type w;
      w = req_type'({$urandom, $urandom});
      case (kind)
         EV_SHUT_IRQ: begin
            w.mode = MODE_EXT_IRQ;
            // shut the window for one reason at least
            case ($urandom_range(0, 3))
               0: w.guest_if = 1'b0;
               1: w.activity_state = $urandom_range(0, 1) ? ACT_SHUTDOWN : ACT_SIPI;
               2: w.sti_blocking = 1'b1;
               default: w.movss_blocking = 1'b1;
            endcase
         end
         EV_OPEN_IRQ: begin
            w.mode           = MODE_EXT_IRQ;
            w.guest_if       = 1'b1;
            w.activity_state = $urandom_range(0, 1) ? ACT_HALT : ACT_ACTIVE;
            w.sti_blocking   = 1'b0;
            w.movss_blocking = 1'b0;
         end
         EV_WINDOW: w.mode = MODE_WINDOW;
         default: ;
      endcase
      return w;
   endfunction

   // Offer one word and hold it until it is taken
   task automatic send_event(req_type w);
      while (!steady_run && $urandom_range(0, 99) < 11) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
   endtask

   initial begin
      int unsigned sent;
      int unsigned burst;
      int          pick;
      int          kind;
      int unsigned calm_from;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty window exit, extremes, each shut reason, backlog, drain
      send_event(event_word(MODE_WINDOW, 8'h00, 1'b0, ACT_ACTIVE, 1'b0, 1'b0));
      send_event(event_word(MODE_EXT_IRQ, 8'h00, 1'b1, ACT_ACTIVE, 1'b0, 1'b0));
      send_event(event_word(MODE_EXT_IRQ, 8'hFF, 1'b1, ACT_HALT, 1'b0, 1'b0));
      send_event(event_word(MODE_EXT_IRQ, 8'hA5, 1'b0, ACT_ACTIVE, 1'b0, 1'b0));
      send_event(event_word(MODE_EXT_IRQ, 8'h5A, 1'b1, ACT_SHUTDOWN, 1'b0, 1'b0));
      send_event(event_word(MODE_EXT_IRQ, 8'h01, 1'b1, ACT_SIPI, 1'b0, 1'b0));
      send_event(event_word(MODE_EXT_IRQ, 8'h80, 1'b1, ACT_ACTIVE, 1'b1, 1'b0));
      send_event(event_word(MODE_EXT_IRQ, 8'hFF, 1'b1, ACT_HALT, 1'b0, 1'b1));
      send_event(event_word(MODE_EXT_IRQ, 8'h00, 1'b0, ACT_SIPI, 1'b1, 1'b1));
      send_event(event_word(MODE_EXT_IRQ, 8'h42, 1'b1, ACT_ACTIVE, 1'b0, 1'b0));
      repeat (6) begin
         send_event(event_word(MODE_WINDOW, 8'h00, 1'b1, ACT_ACTIVE, 1'b0, 1'b0));
      end
      send_event(event_word(MODE_WINDOW, 8'hFF, 1'b1, ACT_SIPI, 1'b1, 1'b1));

      // Random: fill, drain, mixed and noise bursts; one stretch without idling
      sent      = 0;
      calm_from = $urandom_range(500, 1200);
      while (sent < EVENTS) begin
         pick  = $urandom_range(0, 9);
         burst = (pick < 3) ? $urandom_range(20, 45) : $urandom_range(10, 40);
         repeat (burst) begin
            steady_run = (sent >= calm_from) && (sent < calm_from + 400);
            kind = $urandom_range(0, 99);
            if (pick < 3) begin
               kind = (kind < 85) ? EV_SHUT_IRQ : (kind < 95) ? EV_OPEN_IRQ : EV_WINDOW;
            end else if (pick < 6) begin
               kind = (kind < 85) ? EV_WINDOW : EV_ANY;
            end else if (pick < 9) begin
               kind = kind % 3;
            end else begin
               kind = EV_ANY;
            end
            send_event(random_event(kind));
            sent++;
         end
      end
      req_valid <= 1'b0;
      steady_run = 1'b0;

      // Let the last responses drain
      @(posedge clock);
      while (sb.awaited() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_WAIT) @(posedge clock);
      if (sb.faults == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
